/* rtl/tcr_pkg.sv */
`timescale 1ns / 1ps
package tcr_pkg;

    // Number of material slots carried by one node transaction.
    localparam int NUM_SLOTS = 4;
    localparam int DEF_MAX_MATERIALS = 4;

    // Field widths.
    localparam int TEMP_W = 24;
    localparam int MASS_W = 24;
    localparam int CAP_W = 16;
    localparam int INV_W = 32;
    localparam int RATE_W = 32;
    localparam int CNT_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // Derived arithmetic widths.
    localparam int WEIGHT_W = MASS_W + CAP_W;             // 40
    localparam int HALF_W = WEIGHT_W / 2;                 // 20
    localparam int TERM_W = WEIGHT_W + TEMP_W;            // 64
    localparam int DEN_W = WEIGHT_W + 2;                  // 42
    localparam int NUM_W = TERM_W + 2;                    // 66
    localparam int PROD_W = TEMP_W + INV_W;               // 56

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MATERIAL_COUNT = 3'd0,
        REG_HEAT_CAP_0     = 3'd1,
        REG_HEAT_CAP_1     = 3'd2,
        REG_HEAT_CAP_2     = 3'd3,
        REG_HEAT_CAP_3     = 3'd4,
        REG_INV_TIME_STEP  = 3'd5
    } t_cfg_reg;

endpackage

/* rtl/tcr_in_if.sv */
`timescale 1ns / 1ps
interface tcr_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] temp_0;
    logic [23:0] temp_1;
    logic [23:0] temp_2;
    logic [23:0] temp_3;
    logic [23:0] mass_0;
    logic [23:0] mass_1;
    logic [23:0] mass_2;
    logic [23:0] mass_3;

    modport source (output valid, temp_0, temp_1, temp_2, temp_3,
                    mass_0, mass_1, mass_2, mass_3, input ready);
    modport sink (input valid, temp_0, temp_1, temp_2, temp_3,
                  mass_0, mass_1, mass_2, mass_3, output ready);
endinterface

/* rtl/tcr_out_if.sv */
`timescale 1ns / 1ps
interface tcr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] rate_0;
    logic signed [31:0] rate_1;
    logic signed [31:0] rate_2;
    logic signed [31:0] rate_3;
    logic               zero_weight;

    modport source (output valid, rate_0, rate_1, rate_2, rate_3, zero_weight,
                    input ready);
    modport sink (input valid, rate_0, rate_1, rate_2, rate_3, zero_weight,
                  output ready);
endinterface

/* rtl/tcr_weight_lane.sv */
`timescale 1ns / 1ps
module tcr_weight_lane
    import tcr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [MASS_W-1:0] i_mass,
    input  logic [CAP_W-1:0]  i_cap,
    input  logic [TEMP_W-1:0] i_temp,
    output logic [WEIGHT_W-1:0] o_weight,
    output logic [TERM_W-1:0] o_term,
    output logic [TEMP_W-1:0] o_temp
);
    logic [WEIGHT_W-1:0] r_w1, r_w2, r_w3;
    logic [TEMP_W-1:0]   r_t1, r_t2, r_t3;
    logic [HALF_W+TEMP_W-1:0] r_plo, r_phi;
    logic [TERM_W-1:0]   r_term;

    // Weight, then two half-width partial products, then the full term.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w1   <= i_mass * i_cap;
            r_t1   <= i_temp;
            r_plo  <= r_w1[HALF_W-1:0] * r_t1;
            r_phi  <= r_w1[WEIGHT_W-1:HALF_W] * r_t1;
            r_w2   <= r_w1;
            r_t2   <= r_t1;
            r_term <= TERM_W'(r_plo) + (TERM_W'(r_phi) << HALF_W);
            r_w3   <= r_w2;
            r_t3   <= r_t2;
        end
    end

    assign o_weight = r_w3;
    assign o_term   = r_term;
    assign o_temp   = r_t3;
endmodule

/* rtl/tcr_divider.sv */
`timescale 1ns / 1ps
module tcr_divider
    import tcr_pkg::*;
#(
    parameter int SIDE_W = NUM_SLOTS * TEMP_W
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic [TEMP_W-1:0] o_quot,
    output logic [DEN_W-1:0]  o_rem,
    output logic [DEN_W-1:0]  o_den,
    output logic [SIDE_W-1:0] o_side
);
    // One quotient bit per stage; the quotient is a weighted mean of
    // temperatures and so never exceeds the temperature width.
    logic [NUM_W-1:0]  r_rem  [0:TEMP_W];
    logic [TEMP_W-1:0] r_quot [0:TEMP_W];
    logic [DEN_W-1:0]  r_den  [0:TEMP_W];
    logic [SIDE_W-1:0] r_side [0:TEMP_W];

    assign r_rem[0]  = i_num;
    assign r_quot[0] = '0;
    assign r_den[0]  = i_den;
    assign r_side[0] = i_side;

    for (genvar k = 0; k < TEMP_W; k++) begin : g_stage
        localparam int B = TEMP_W - 1 - k;
        logic [NUM_W-1:0] trial;
        logic             take;
        assign trial = NUM_W'(r_den[k]) << B;
        assign take  = r_rem[k] >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= take ? (r_rem[k] - trial) : r_rem[k];
                r_quot[k+1] <= r_quot[k] | (take ? (TEMP_W'(1) << B) : '0);
                r_den[k+1]  <= r_den[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_quot = r_quot[TEMP_W];
    assign o_rem  = r_rem[TEMP_W][DEN_W-1:0];
    assign o_den  = r_den[TEMP_W];
    assign o_side = r_side[TEMP_W];
endmodule

/* rtl/tcr_rate_lane.sv */
`timescale 1ns / 1ps
module tcr_rate_lane
    import tcr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [TEMP_W-1:0] i_tc,
    input  logic [TEMP_W-1:0] i_temp,
    input  logic [INV_W-1:0]  i_inv,
    input  logic              i_kill,
    output logic signed [RATE_W-1:0] o_rate
);
    localparam int RND_W = PROD_W - 15;

    logic                 neg;
    logic [TEMP_W-1:0]    mag;
    logic [PROD_W-1:0]    r_prod;
    logic                 r_neg, r_kill;
    logic [RND_W-1:0]     rnd;
    logic [RATE_W-1:0]    n_rate;
    logic [RATE_W-1:0]    r_rate;

    assign neg = i_tc < i_temp;
    assign mag = neg ? (i_temp - i_tc) : (i_tc - i_temp);

    // Rounding: half a unit added to the magnitude, ties away from zero.
    assign rnd = RND_W'((r_prod + PROD_W'(32768)) >> 16);

    always_comb begin
        if (r_kill) begin
            n_rate = '0;
        end else if (r_neg) begin
            if (rnd >= RND_W'(64'h8000_0000)) n_rate = 32'h8000_0000;
            else n_rate = RATE_W'(0) - rnd[RATE_W-1:0];
        end else begin
            if (rnd > RND_W'(64'h7FFF_FFFF)) n_rate = 32'h7FFF_FFFF;
            else n_rate = rnd[RATE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= mag * i_inv;
            r_neg  <= neg;
            r_kill <= i_kill;
            r_rate <= n_rate;
        end
    end

    assign o_rate = signed'(r_rate);
endmodule

/* rtl/thermal_contact_rate_top.sv */
`timescale 1ns / 1ps
// Channel  Dir  Fields                                   Handshake
// i_in     in   temp_0..3 (Q16.8), mass_0..3 (Q4.20)     valid / ready
// o_out    out  rate_0..3 (Q24.8), zero_weight           valid / ready
// i_cfg_*  in   index, data                              write enable only
//
// One node transaction is accepted per cycle unless the sink holds a result;
// results pass weight lanes, merge, 24 radix-2 divider stages, rounding, rates.
// Synchronous active-low reset clears the valid pipeline and sets the config registers; pipeline data is not reset.
// The whole pipeline advances together and halts only while a result at the
// output register is held by the sink.
module thermal_contact_rate_top
    import tcr_pkg::*;
#(
    parameter int MAX_MATERIALS = DEF_MAX_MATERIALS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tcr_in_if.sink                i_in,
    tcr_out_if.source             o_out
);
    localparam int LAT = 3 + 1 + TEMP_W + 1 + 2;
    localparam int CLAMP = (MAX_MATERIALS < NUM_SLOTS) ? MAX_MATERIALS : NUM_SLOTS;

    // Configuration registers.
    logic [CNT_W-1:0] r_count;
    logic [CAP_W-1:0] r_cap [NUM_SLOTS];
    logic [INV_W-1:0] r_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CNT_W'(1);
            for (int m = 0; m < NUM_SLOTS; m++) r_cap[m] <= CAP_W'(16);
            r_inv <= INV_W'(65536);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MATERIAL_COUNT: r_count  <= i_cfg_data[CNT_W-1:0];
                REG_HEAT_CAP_0:     r_cap[0] <= i_cfg_data[CAP_W-1:0];
                REG_HEAT_CAP_1:     r_cap[1] <= i_cfg_data[CAP_W-1:0];
                REG_HEAT_CAP_2:     r_cap[2] <= i_cfg_data[CAP_W-1:0];
                REG_HEAT_CAP_3:     r_cap[3] <= i_cfg_data[CAP_W-1:0];
                REG_INV_TIME_STEP:  r_inv    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Active materials: the count clamped to the lane limit.
    logic [NUM_SLOTS-1:0] active;
    always_comb begin
        for (int m = 0; m < NUM_SLOTS; m++) begin
            active[m] = (32'(r_count) > m) && (m < CLAMP);
        end
    end

    // Pipeline advance and valid tracking.
    logic           en;
    logic [LAT-1:0] r_vld;
    assign en = !r_vld[LAT-1] || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    // Weight lanes; an inactive lane sees zero mass and adds nothing.
    logic [MASS_W-1:0]   in_mass [NUM_SLOTS];
    logic [TEMP_W-1:0]   in_temp [NUM_SLOTS];
    logic [WEIGHT_W-1:0] l_w     [NUM_SLOTS];
    logic [TERM_W-1:0]   l_term  [NUM_SLOTS];
    logic [TEMP_W-1:0]   l_temp  [NUM_SLOTS];

    assign in_mass[0] = i_in.mass_0;
    assign in_mass[1] = i_in.mass_1;
    assign in_mass[2] = i_in.mass_2;
    assign in_mass[3] = i_in.mass_3;
    assign in_temp[0] = i_in.temp_0;
    assign in_temp[1] = i_in.temp_1;
    assign in_temp[2] = i_in.temp_2;
    assign in_temp[3] = i_in.temp_3;

    for (genvar m = 0; m < NUM_SLOTS; m++) begin : g_weight
        tcr_weight_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_mass   (active[m] ? in_mass[m] : '0),
            .i_cap    (r_cap[m]),
            .i_temp   (in_temp[m]),
            .o_weight (l_w[m]),
            .o_term   (l_term[m]),
            .o_temp   (l_temp[m])
        );
    end

    // Merge: sums of weights and weighted temperatures.
    logic [DEN_W-1:0] n_den, r_den;
    logic [NUM_W-1:0] n_num, r_num;
    logic [NUM_SLOTS*TEMP_W-1:0] r_mtemp;

    always_comb begin
        n_den = '0;
        n_num = '0;
        for (int m = 0; m < NUM_SLOTS; m++) begin
            n_den = n_den + DEN_W'(l_w[m]);
            n_num = n_num + NUM_W'(l_term[m]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_den <= n_den;
            r_num <= n_num;
            for (int m = 0; m < NUM_SLOTS; m++) begin
                r_mtemp[m*TEMP_W +: TEMP_W] <= l_temp[m];
            end
        end
    end

    // Contact temperature.
    logic [TEMP_W-1:0]           d_quot;
    logic [DEN_W-1:0]            d_rem, d_den;
    logic [NUM_SLOTS*TEMP_W-1:0] d_temp;

    tcr_divider #(.SIDE_W(NUM_SLOTS * TEMP_W)) u_div (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (r_num),
        .i_den  (r_den),
        .i_side (r_mtemp),
        .o_quot (d_quot),
        .o_rem  (d_rem),
        .o_den  (d_den),
        .o_side (d_temp)
    );

    // Round to nearest, ties upward, and flag an empty weight sum.
    logic [TEMP_W-1:0]           r_tc;
    logic                        r_zero;
    logic [NUM_SLOTS*TEMP_W-1:0] r_rtemp;
    logic [1:0]                  r_zero_d;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tc     <= d_quot + TEMP_W'({d_rem, 1'b0} >= {1'b0, d_den});
            r_zero   <= d_den == '0;
            r_rtemp  <= d_temp;
            r_zero_d <= {r_zero_d[0], r_zero};
        end
    end

    // Rate lanes.
    logic signed [RATE_W-1:0] l_rate [NUM_SLOTS];

    for (genvar m = 0; m < NUM_SLOTS; m++) begin : g_rate
        tcr_rate_lane u_rate (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_tc   (r_tc),
            .i_temp (r_rtemp[m*TEMP_W +: TEMP_W]),
            .i_inv  (r_inv),
            .i_kill (r_zero || !active[m]),
            .o_rate (l_rate[m])
        );
    end

    assign o_out.valid       = r_vld[LAT-1];
    assign o_out.rate_0      = l_rate[0];
    assign o_out.rate_1      = l_rate[1];
    assign o_out.rate_2      = l_rate[2];
    assign o_out.rate_3      = l_rate[3];
    assign o_out.zero_weight = r_zero_d[1];

    // An empty weight sum always yields zero rates.
    a_zero_rates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.zero_weight) |->
        (o_out.rate_0 == 0 && o_out.rate_1 == 0 && o_out.rate_2 == 0
         && o_out.rate_3 == 0))
        else $error("rates not zero with zero weight");

    // A stalled result stays at the output.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> o_out.valid)
        else $error("result dropped under stall");

    // A transaction taken in enters the valid pipeline.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_vld[0])
        else $error("accepted transaction lost");
endmodule
